// File: rtl/multiple_flow_direction_weight_defines.svh
// Assertion macros for the flow weight block.
// Both expect clk and arst_n in scope at the point of use.
`ifndef MULTIPLE_FLOW_DIRECTION_WEIGHT_DEFINES_SVH
`define MULTIPLE_FLOW_DIRECTION_WEIGHT_DEFINES_SVH

`ifndef SYNTHESIS
`define MFDW_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define MFDW_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MFDW_ASSERT(lbl, prop, msg)
`define MFDW_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// File: rtl/mfdw_pkg.sv
package mfdw_pkg;

	localparam int ElevW   = 24;
	localparam int DropW   = ElevW + 1;
	localparam int SoW     = DropW + 2;   // four drops summed
	localparam int ScaleW  = 16;
	localparam int SumW    = SoW + ScaleW + 1;
	localparam int ChosenW = ElevW + ScaleW;
	localparam int DenW    = SumW - 1;    // positive sum magnitude
	localparam int WeightW = 16;
	localparam int QBits   = 16;
	localparam int CntW    = 4;

	// 65536/sqrt2 rounded to nearest; orthogonal slopes are a plain shift
	localparam logic [ScaleW-1:0] DiagScale = 16'd46341;
	localparam int OrthoShift = ScaleW;

	localparam logic [WeightW-1:0] OneQ15 = 16'h8000;

	typedef enum logic [1:0] {
		CLS_ONE,
		CLS_MISS,
		CLS_NONE,
		CLS_CALC
	} cls_t;

	typedef struct packed {
		logic               known;
		logic [WeightW-1:0] weight;
		logic               miss;
		logic [DenW-1:0]    num;
		logic [DenW-1:0]    den;
		logic [QBits-1:0]   quo;
	} div_t;

	// 1/count, rounded half up, for the flat case
	function automatic logic [WeightW-1:0] flat_weight(input logic [CntW-1:0] cnt);
		logic [WeightW-1:0] w;
		case (cnt)
			4'd2: w = 16'd16384;
			4'd3: w = 16'd10923;
			4'd4: w = 16'd8192;
			4'd5: w = 16'd6554;
			4'd6: w = 16'd5461;
			4'd7: w = 16'd4681;
			4'd8: w = 16'd4096;
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

// File: rtl/mfdw_in_if.sv
interface mfdw_in_if;
	logic               valid;
	logic               ready;
	logic signed [23:0] center_elev;
	logic signed [23:0] nbr_elev_0;
	logic signed [23:0] nbr_elev_1;
	logic signed [23:0] nbr_elev_2;
	logic signed [23:0] nbr_elev_3;
	logic signed [23:0] nbr_elev_4;
	logic signed [23:0] nbr_elev_5;
	logic signed [23:0] nbr_elev_6;
	logic signed [23:0] nbr_elev_7;
	logic [7:0]         outflow_mask;
	logic [8:0]         missing_mask;
	logic [2:0]         direction;

	modport source (
		output valid, center_elev, nbr_elev_0, nbr_elev_1, nbr_elev_2, nbr_elev_3,
			nbr_elev_4, nbr_elev_5, nbr_elev_6, nbr_elev_7, outflow_mask,
			missing_mask, direction,
		input ready
	);
	modport sink (
		input valid, center_elev, nbr_elev_0, nbr_elev_1, nbr_elev_2, nbr_elev_3,
			nbr_elev_4, nbr_elev_5, nbr_elev_6, nbr_elev_7, outflow_mask,
			missing_mask, direction,
		output ready
	);
endinterface

// File: rtl/mfdw_out_if.sv
interface mfdw_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] weight;
	logic        weight_missing;

	modport source (output valid, weight, weight_missing, input ready);
	modport sink (input valid, weight, weight_missing, output ready);
endinterface

// File: rtl/mfdw_slope.sv
module mfdw_slope (
	input  logic            clk,
	input  logic            arst_n,
	mfdw_in_if.sink         req,
	output logic            out_valid,
	input  logic            out_ready,
	output mfdw_pkg::div_t  out_data
);
	import mfdw_pkg::*;

	logic en1, en2, en3, en4;
	logic v_s1, v_s2, v_s3, v_s4;

	// stage 1: drops, masked partial sums, class
	logic signed [ElevW-1:0] nbr [8];
	logic signed [DropW-1:0] drop [8];
	logic signed [SoW-1:0]   so_c, sd_c;
	logic [CntW-1:0]         cnt_c;
	cls_t                    cls_c;
	logic signed [DropW-1:0] cd;
	logic [ElevW-1:0]        cd_pos;

	cls_t                    cls_s1;
	logic [CntW-1:0]         cnt_s1;
	logic signed [SoW-1:0]   so_s1, sd_s1;
	logic [ElevW-1:0]        cd_s1;
	logic                    diag_s1;

	// stage 2: products
	cls_t                    cls_s2;
	logic [CntW-1:0]         cnt_s2;
	logic signed [SoW-1:0]   so_s2;
	logic signed [SumW-1:0]  prodd_s2;
	logic [ChosenW-1:0]      chosen_s2;

	// stage 3: full sum
	cls_t                    cls_s3;
	logic [CntW-1:0]         cnt_s3;
	logic signed [SumW-1:0]  sum_s3;
	logic [ChosenW-1:0]      chosen_s3;

	// stage 4: decision, division operands
	div_t                    dec_c;
	div_t                    dec_s4;

	assign en4 = !v_s4 || out_ready;
	assign en3 = !v_s3 || en4;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign req.ready = en1;

	assign nbr[0] = req.nbr_elev_0;
	assign nbr[1] = req.nbr_elev_1;
	assign nbr[2] = req.nbr_elev_2;
	assign nbr[3] = req.nbr_elev_3;
	assign nbr[4] = req.nbr_elev_4;
	assign nbr[5] = req.nbr_elev_5;
	assign nbr[6] = req.nbr_elev_6;
	assign nbr[7] = req.nbr_elev_7;

	always_comb begin
		so_c  = '0;
		sd_c  = '0;
		cnt_c = '0;
		for (int k = 0; k < 8; k++) begin
			drop[k] = DropW'(req.center_elev) - DropW'(nbr[k]);
			cnt_c   = cnt_c + CntW'(req.outflow_mask[k]);
			if (req.outflow_mask[k] && !req.missing_mask[k]) begin
				if (k % 2 == 1)
					sd_c = sd_c + SoW'(drop[k]);
				else
					so_c = so_c + SoW'(drop[k]);
			end
		end
		cd = drop[req.direction];
		cd_pos = (!cd[DropW-1] && (cd != '0)) ? cd[ElevW-1:0] : '0;
		if (cnt_c == CntW'(1))
			cls_c = CLS_ONE;
		else if (req.missing_mask[8] || req.missing_mask[{1'b0, req.direction}])
			cls_c = CLS_MISS;
		else if (cnt_c == '0)
			cls_c = CLS_NONE;
		else
			cls_c = CLS_CALC;
	end

	always_comb begin
		dec_c        = '0;
		dec_c.known  = 1'b1;
		dec_c.num    = DenW'(chosen_s3);
		dec_c.den    = sum_s3[DenW-1:0];
		case (cls_s3)
			CLS_ONE:  dec_c.weight = OneQ15;
			CLS_MISS: dec_c.miss = 1'b1;
			CLS_NONE: dec_c.weight = '0;
			CLS_CALC: begin
				if (sum_s3 == '0)
					dec_c.weight = flat_weight(cnt_s3);
				else if (sum_s3[SumW-1] || (chosen_s3 == '0))
					dec_c.weight = '0;
				else if (DenW'(chosen_s3) >= sum_s3[DenW-1:0])
					dec_c.weight = OneQ15;
				else
					dec_c.known = 1'b0;
			end
			default: dec_c.miss = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= req.valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			cls_s1  <= cls_c;
			cnt_s1  <= cnt_c;
			so_s1   <= so_c;
			sd_s1   <= sd_c;
			cd_s1   <= cd_pos;
			diag_s1 <= req.direction[0];
		end
		if (en2) begin
			cls_s2   <= cls_s1;
			cnt_s2   <= cnt_s1;
			so_s2    <= so_s1;
			prodd_s2 <= SumW'(sd_s1) * SumW'($signed({1'b0, DiagScale}));
			chosen_s2 <= diag_s1 ? ChosenW'(cd_s1) * ChosenW'(DiagScale)
				: {cd_s1, {OrthoShift{1'b0}}};
		end
		if (en3) begin
			cls_s3    <= cls_s2;
			cnt_s3    <= cnt_s2;
			sum_s3    <= (SumW'(so_s2) <<< OrthoShift) + prodd_s2;
			chosen_s3 <= chosen_s2;
		end
		if (en4)
			dec_s4 <= dec_c;
	end

	assign out_valid = v_s4;
	assign out_data  = dec_s4;

endmodule

// File: rtl/mfdw_div.sv
module mfdw_div (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  mfdw_pkg::div_t  in_data,
	mfdw_out_if.source      rsp
);
	import mfdw_pkg::*;

	div_t            stage_s [QBits];
	div_t            step_c  [QBits];
	logic [QBits-1:0] vld_s;
	logic [QBits:0]  en;

	logic [WeightW-1:0] weight_q;
	logic               miss_q;
	logic               valid_q;
	logic [QBits:0]     qr;

	// one quotient bit per stage, remainder stays below the divisor
	function automatic div_t div_step(input div_t x);
		div_t            y;
		logic [DenW:0]   r2;
		logic [DenW:0]   diff;
		logic            ge;
		y = x;
		r2 = {x.num, 1'b0};
		diff = r2 - {1'b0, x.den};
		ge = (r2 >= {1'b0, x.den});
		if (!x.known) begin
			y.num = ge ? diff[DenW-1:0] : r2[DenW-1:0];
			y.quo = {x.quo[QBits-2:0], ge};
		end
		return y;
	endfunction

	assign en[QBits] = !valid_q || rsp.ready;
	assign in_ready  = en[0];

	for (genvar i = 0; i < QBits; i++) begin : g_stage
		if (i == 0) begin : g_first
			assign step_c[i] = div_step(in_data);
			assign en[i] = !vld_s[i] || en[i+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[i] <= 1'b0;
				else if (en[i])
					vld_s[i] <= in_valid;
			end
		end else begin : g_rest
			assign step_c[i] = div_step(stage_s[i-1]);
			assign en[i] = !vld_s[i] || en[i+1];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_s[i] <= 1'b0;
				else if (en[i])
					vld_s[i] <= vld_s[i-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en[i])
				stage_s[i] <= step_c[i];
		end
	end

	// floor(x/2 + 1/2) from the 16-bit floor quotient
	assign qr = {1'b0, stage_s[QBits-1].quo} + (QBits+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (en[QBits])
			valid_q <= vld_s[QBits-1];
	end

	always_ff @(posedge clk) begin
		if (en[QBits]) begin
			weight_q <= stage_s[QBits-1].known ? stage_s[QBits-1].weight : qr[QBits:1];
			miss_q   <= stage_s[QBits-1].miss;
		end
	end

	assign rsp.valid          = valid_q;
	assign rsp.weight         = weight_q;
	assign rsp.weight_missing = miss_q;

endmodule

// File: rtl/multiple_flow_direction_weight.sv
// Multiple flow direction weight: fraction of a cell's flow sent to one neighbour.
//
// req carries one beat per cell direction: centre and eight neighbour elevations,
// outflow and missing masks and the chosen direction. rsp returns one beat per
// request with weight (unsigned Q1.15, 32768 is one) and weight_missing.
// Both channels use valid/ready; a beat moves when both are high.
//
// From request beat to response valid, four stages form the slope sums and classify
// the item, sixteen stages produce one quotient bit each of the restoring divider,
// and a last stage rounds into the output register. Throughput is one beat per
// cycle while rsp is not stalled.
//
// When rsp stalls, each stage holds only while the stage after it is full, so
// bubbles close up and req.ready stays high until all 21 stages hold data.
// Nothing is dropped or repeated under any stall pattern.
// Reset clears every valid bit at once; the block can take a beat as soon as
// arst_n is released.
`include "multiple_flow_direction_weight_defines.svh"

module multiple_flow_direction_weight (
	input  logic       clk,
	input  logic       arst_n,
	mfdw_in_if.sink    req,
	mfdw_out_if.source rsp
);
	import mfdw_pkg::*;

	logic mid_valid;
	logic mid_ready;
	div_t mid_data;

	mfdw_slope u_slope (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.out_valid (mid_valid),
		.out_ready (mid_ready),
		.out_data  (mid_data)
	);

	mfdw_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (mid_valid),
		.in_ready (mid_ready),
		.in_data  (mid_data),
		.rsp      (rsp)
	);

	// back-pressure reaches req only when the output is stalled
	`MFDW_ASSERT(a_ready_only_on_stall, !req.ready |-> (rsp.valid && !rsp.ready), "req stalled with rsp free")
	`MFDW_ASSERT(a_weight_range, rsp.valid |-> ((rsp.weight <= OneQ15) && !(rsp.weight_missing && (rsp.weight != '0))), "weight out of range")
	`MFDW_ASSERT_NEXT(a_div_holds, (mid_valid && !mid_ready), (mid_valid && $stable(mid_data)), "divider input lost under stall")

endmodule
